@@ sv/mpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types, sizes and the median edge predictor for the pixel codec.
// ----------------------------------------------------------------------------
package mpc_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [COL_W-1:0] WIDTH_LAST_RST  = COL_W'(640 - 1);
	localparam logic [15:0]      HEIGHT_LAST_RST = 16'd479;

	// item handed from the scan cell to the predict cell
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             border;
		logic             frame_end;
		logic [PIX_W-1:0] sample;
	} scan_t;

	// line buffer write port
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] data;
	} lb_wr_t;

	function automatic logic [PIX_W-1:0] med_predict(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] c
	);
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		logic [PIX_W:0]   grad;
		lo   = (a < b) ? a : b;
		hi   = (a < b) ? b : a;
		grad = {1'b0, a} + {1'b0, b} - {1'b0, c};
		if (c >= hi) begin
			return lo;
		end else if (c <= lo) begin
			return hi;
		end
		return grad[PIX_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/mpc_line_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_line_buf
// Previous-row line buffer, one write and one registered read per cycle,
// with write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module mpc_line_buf (
	input  wire                           clk,
	input  wire mpc_pkg::lb_wr_t          wr,
	input  wire                           rd_en,
	input  wire [mpc_pkg::COL_W-1:0]      rd_addr,
	output logic [mpc_pkg::PIX_W-1:0]     rd_data
);
	import mpc_pkg::*;

	logic [PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && (wr.addr == rd_addr)) begin
				rd_data_q <= wr.data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ sv/mpc_scan_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_scan_cell
// Input cell: raster counters, column clamp, line buffer read and the
// stage-1 item register handed to the predict cell.
// ----------------------------------------------------------------------------
module mpc_scan_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [mpc_pkg::PIX_W-1:0]      s_tdata,
	input  wire [mpc_pkg::COL_W-1:0]      width_last,
	input  wire [15:0]                    height_last,
	input  wire                           take,
	output mpc_pkg::scan_t                item_s1,
	output logic                          item_valid_s1,
	output logic                          rd_en,
	output logic [mpc_pkg::COL_W-1:0]     rd_addr
);
	import mpc_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [15:0]      row_q;
	logic [COL_W-1:0] col;
	logic             last_col;
	logic             last_row;
	logic             accept;

	assign s_tready = !item_valid_s1 || take;
	assign accept   = s_tvalid && s_tready;
	assign col      = (col_q > width_last) ? width_last : col_q;
	assign last_col = (col == width_last);
	assign last_row = (row_q >= height_last);
	assign rd_en    = accept;
	assign rd_addr  = col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			item_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				item_valid_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col + COL_W'(1);
				end
			end else if (take) begin
				item_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.col       <= col;
			item_s1.border    <= (row_q == 16'd0) || (col == '0);
			item_s1.frame_end <= last_col && last_row;
			item_s1.sample    <= s_tdata;
		end
	end

endmodule
`default_nettype wire

@@ sv/mpc_pred_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pred_cell
// Predict cell: left and upper-left neighbors, MED prediction, residual or
// reconstruction, line buffer write-back and the output register.
// ----------------------------------------------------------------------------
module mpc_pred_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire mpc_pkg::scan_t           item_s1,
	input  wire                           item_valid_s1,
	input  wire [mpc_pkg::PIX_W-1:0]      up,
	input  wire                           decode_mode,
	output logic                          take,
	output mpc_pkg::lb_wr_t               wr,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [mpc_pkg::PIX_W-1:0]     m_tdata,
	output logic                          m_tlast
);
	import mpc_pkg::*;

	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] upper_left_q;
	logic [PIX_W-1:0] pred;
	logic [PIX_W-1:0] pixel;
	logic [PIX_W-1:0] result;

	assign take  = item_valid_s1 && (!m_tvalid || m_tready);
	assign pred  = item_s1.border ? '0 : med_predict(left_q, up, upper_left_q);
	assign pixel = decode_mode ? item_s1.sample + pred : item_s1.sample;
	assign result = decode_mode ? pixel : item_s1.sample - pred;

	assign wr.en   = take;
	assign wr.addr = item_s1.col;
	assign wr.data = pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (take) begin
				left_q       <= pixel;
				upper_left_q <= up;
				m_tvalid     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata <= result;
			m_tlast <= item_s1.frame_end;
		end
	end

endmodule
`default_nettype wire

@@ sv/med_predictive_pixel_codec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// med_predictive_pixel_codec
// JPEG-LS median edge detector codec for 8-bit grayscale raster streams.
//
// Slave stream carries one sample per transaction (pixel when encoding,
// residual when decoding); master stream returns one sample per transaction
// (residual or reconstructed pixel) with tlast on the last pixel of a frame.
// Two cells in a row: the scan cell keeps the raster counters and reads the
// previous-row buffer, the predict cell forms the MED prediction from its
// left and upper-left registers and writes the pixel back to the buffer.
// Throughput: one transaction per cycle while the receiver does not stall;
// the left-pixel feedback closes inside the predict cell and the line buffer
// takes one read and one write per cycle. An accepted input passes through
// the stage-1 item register and then the output register.
// When the receiver stalls, the output register holds, the stage-1 item
// waits, and s_tready drops only while both are full.
// Reset clears counters, neighbors and handshake state; registers return to
// encode mode, 640 x 480. The line buffer is not cleared: each entry is
// written in the first row before its value is used in a prediction.
// Configuration is written through cfg_we / cfg_addr / cfg_data while idle.
// ----------------------------------------------------------------------------
module med_predictive_pixel_codec (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [mpc_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire [mpc_pkg::CFG_W-1:0]          cfg_data,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [7:0]                         s_tdata,   // [7:0] sample_in
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] sample_out
	output logic                              m_tlast    // frame_end
);
	import mpc_pkg::*;

	logic             decode_mode_q;
	logic [COL_W-1:0] width_last_q;
	logic [15:0]      height_last_q;

	scan_t            item_s1;
	logic             item_valid_s1;
	logic             take;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	logic [PIX_W-1:0] up;
	lb_wr_t           wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			width_last_q  <= WIDTH_LAST_RST;
			height_last_q <= HEIGHT_LAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DECODE_MODE: begin
					decode_mode_q <= cfg_data[0];
				end
				REG_FRAME_WIDTH: begin
					if (cfg_data[11:0] == 12'd0) begin
						width_last_q <= '0;
					end else if (int'(cfg_data[11:0]) > MAX_WIDTH) begin
						width_last_q <= COL_W'(MAX_WIDTH - 1);
					end else begin
						width_last_q <= COL_W'(cfg_data[11:0] - 12'd1);
					end
				end
				REG_FRAME_HEIGHT: begin
					height_last_q <= (cfg_data == 16'd0) ? 16'd0 : cfg_data - 16'd1;
				end
				default: begin
				end
			endcase
		end
	end

	mpc_scan_cell u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.width_last    (width_last_q),
		.height_last   (height_last_q),
		.take          (take),
		.item_s1       (item_s1),
		.item_valid_s1 (item_valid_s1),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr)
	);

	mpc_line_buf u_lbuf (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (up)
	);

	mpc_pred_cell u_pred (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_s1       (item_s1),
		.item_valid_s1 (item_valid_s1),
		.up            (up),
		.decode_mode   (decode_mode_q),
		.take          (take),
		.wr            (wr),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

endmodule
`default_nettype wire

@@ sv/mpc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_checker
// Port-level checks for the pixel codec, bound to the top level.
// ----------------------------------------------------------------------------
module mpc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction dropped or changed while stalled");

	// input side blocks only while the output register is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

	// an output appears from empty only after an input transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output without matching input transaction");

	// with an empty output the input side is always ready
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind med_predictive_pixel_codec mpc_checker u_mpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MED predictive pixel codec.
//
// A short directed table covers the reset geometry, the three MED branches,
// modulo-256 wrap in both modes, degenerate width/height settings and
// counters left past a shrunk limit. A random part then runs many short
// segments with new mode/width/height settings between them. A local
// predictor tracks the raster state and line buffer and queues one expected
// output per accepted input; the output monitor compares sample and
// frame-end flag in order.
// ----------------------------------------------------------------------------
module tb_top;
	import mpc_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int NUM_SEGS     = 30;
	localparam int SEG_ITEMS    = 50;
	localparam int DIR_ROWS     = 32;

	typedef struct packed {
		logic [7:0] sample;
		logic       frame_end;
	} codec_out_t;

	typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] addr;
		logic [CFG_W-1:0]     data;
		logic                 typed;
		logic [7:0]           want_sample;
		logic                 want_last;
	} dir_row_t;

	// typed-in results only where no MED arithmetic is involved
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_PIX, '0, 16'h0000, 1'b1, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'h00FF, 1'b1, 8'hFF, 1'b0},
		'{ROW_CFG, REG_FRAME_WIDTH, 16'd2, 1'b0, 8'h00, 1'b0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 16'd0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'h0080, 1'b1, 8'h80, 1'b1},
		'{ROW_CFG, REG_FRAME_HEIGHT, 16'd2, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'd10, 1'b1, 8'd10, 1'b0},
		'{ROW_PIX, '0, 16'd200, 1'b1, 8'd200, 1'b0},
		'{ROW_PIX, '0, 16'd50, 1'b1, 8'd50, 1'b0},
		'{ROW_PIX, '0, 16'd30, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'd200, 1'b1, 8'd200, 1'b0},
		'{ROW_PIX, '0, 16'd100, 1'b1, 8'd100, 1'b0},
		'{ROW_PIX, '0, 16'd50, 1'b1, 8'd50, 1'b0},
		'{ROW_PIX, '0, 16'd0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'd1, 1'b1, 8'd1, 1'b0},
		'{ROW_PIX, '0, 16'd255, 1'b1, 8'd255, 1'b0},
		'{ROW_PIX, '0, 16'd0, 1'b1, 8'd0, 1'b0},
		'{ROW_PIX, '0, 16'd255, 1'b0, 8'h00, 1'b0},
		'{ROW_CFG, REG_DECODE_MODE, 16'd1, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'h00FF, 1'b1, 8'hFF, 1'b0},
		'{ROW_PIX, '0, 16'h00FF, 1'b1, 8'hFF, 1'b0},
		'{ROW_PIX, '0, 16'h00FF, 1'b1, 8'hFF, 1'b0},
		'{ROW_PIX, '0, 16'h00FF, 1'b0, 8'h00, 1'b0},
		'{ROW_CFG, REG_FRAME_WIDTH, 16'd0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'd7, 1'b1, 8'd7, 1'b0},
		'{ROW_PIX, '0, 16'd9, 1'b1, 8'd9, 1'b1},
		'{ROW_CFG, REG_DECODE_MODE, 16'd0, 1'b0, 8'h00, 1'b0},
		'{ROW_CFG, REG_FRAME_WIDTH, 16'd4095, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'h0055, 1'b1, 8'h55, 1'b0},
		'{ROW_PIX, '0, 16'h00AA, 1'b1, 8'hAA, 1'b0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 16'd65535, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, '0, 16'h003C, 1'b1, 8'h3C, 1'b0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;

	// predictor state
	logic [7:0]  line_buf [MAX_WIDTH];
	logic [7:0]  left_pix     = '0;
	logic [7:0]  upleft_pix   = '0;
	int          col_cnt      = 0;
	int          row_cnt      = 0;
	int          lb_filled    = 0;
	logic        codec_mode   = 1'b0;
	logic [11:0] width_reg    = 12'd640;
	logic [15:0] height_reg   = 16'd480;

	codec_out_t  expected_outputs [$];
	int          mismatch_cnt  = 0;
	int          cycle_cnt     = 0;
	int          src_idle_pct  = 0;
	int          sink_idle_pct = 0;

	med_predictive_pixel_codec uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_width(input logic [11:0] w);
		if (w == 0) begin
			return 1;
		end else if (int'(w) > MAX_WIDTH) begin
			return MAX_WIDTH;
		end
		return int'(w);
	endfunction

	// growing the width past the filled part of the line buffer is only
	// allowed in row 0, where upper neighbors are never used
	function automatic bit width_ok(input logic [11:0] w);
		return (row_cnt == 0) || (eff_width(w) <= lb_filled);
	endfunction

	function automatic void med_codec_predict(input logic [7:0] smp, output codec_out_t res);
		int         w;
		int         h;
		int         colx;
		int         a;
		int         b;
		int         c;
		int         lo;
		int         hi;
		int         pred;
		logic [7:0] up;
		logic [7:0] pix;
		logic       last_col;
		logic       last_row;
		w    = eff_width(width_reg);
		h    = (height_reg == 0) ? 1 : int'(height_reg);
		colx = (col_cnt >= w) ? w - 1 : col_cnt;
		up   = line_buf[colx];
		pred = 0;
		if (row_cnt > 0 && colx > 0) begin
			a  = int'(left_pix);
			b  = int'(up);
			c  = int'(upleft_pix);
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			if (c >= hi) begin
				pred = lo;
			end else if (c <= lo) begin
				pred = hi;
			end else begin
				pred = a + b - c;
			end
		end
		if (codec_mode) begin
			pix        = 8'(int'(smp) + pred);
			res.sample = pix;
		end else begin
			pix        = smp;
			res.sample = 8'(int'(smp) - pred);
		end
		line_buf[colx] = pix;
		upleft_pix     = up;
		left_pix       = pix;
		if (colx + 1 > lb_filled) begin
			lb_filled = colx + 1;
		end
		last_col      = (colx >= w - 1);
		last_row      = (row_cnt >= h - 1);
		res.frame_end = last_col && last_row;
		if (last_col) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : ((row_cnt + 1) & 16'hFFFF);
		end else begin
			col_cnt = colx + 1;
		end
	endfunction

	// all driver tasks are entered and left just after a falling edge
	task automatic send_sample(input logic [7:0] smp, input bit typed, input codec_out_t typed_out);
		codec_out_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		med_codec_predict(smp, predicted);
		expected_outputs.push_back(typed ? typed_out : predicted);
		@(negedge clk);
	endtask

	task automatic wait_pipeline_empty();
		s_tvalid <= 1'b0;
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DECODE_MODE:  codec_mode = val[0];
			REG_FRAME_WIDTH:  width_reg  = val[11:0];
			REG_FRAME_HEIGHT: height_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : out_check
		codec_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_outputs.size() == 0) begin
				if (mismatch_cnt < 10) begin
					$display("%0t: unexpected output sample %02h last %0b",
						$realtime, m_tdata, m_tlast);
				end
				mismatch_cnt++;
			end else begin
				want = expected_outputs.pop_front();
				if (m_tdata !== want.sample || m_tlast !== want.frame_end) begin
					if (mismatch_cnt < 10) begin
						$display("%0t: output mismatch: expected sample %02h last %0b, got %02h %0b",
							$realtime, want.sample, want.frame_end, m_tdata, m_tlast);
					end
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		codec_out_t  tv;
		logic [7:0]  smp;
		logic [7:0]  last_smp;
		logic [11:0] wv;
		logic [15:0] hv;
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		last_smp = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		src_idle_pct  = 8;
		sink_idle_pct = 69;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				wait_pipeline_empty();
				write_reg(DIR_TAB[i].addr, DIR_TAB[i].data);
			end else begin
				tv.sample    = DIR_TAB[i].want_sample;
				tv.frame_end = DIR_TAB[i].want_last;
				send_sample(DIR_TAB[i].data[7:0], DIR_TAB[i].typed, tv);
			end
		end

		// random segments, new settings between them
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg < NUM_SEGS / 3) begin
				src_idle_pct  = 8;
				sink_idle_pct = 69;
			end else if (seg < 2 * NUM_SEGS / 3) begin
				src_idle_pct  = 69;
				sink_idle_pct = 8;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			wait_pipeline_empty();
			if ($urandom_range(1) == 1) begin
				write_reg(REG_DECODE_MODE, CFG_W'($urandom_range(1)));
			end
			if ($urandom_range(1) == 1) begin
				case ($urandom_range(5))
					0: wv = 12'd0;
					1: wv = 12'd1;
					2: wv = 12'($urandom_range(2, 8));
					3: wv = 12'($urandom_range(9, 40));
					4: wv = 12'($urandom_range(2049, 4095));
					default: wv = 12'($urandom_range(41, 300));
				endcase
				if (width_ok(wv)) begin
					write_reg(REG_FRAME_WIDTH, CFG_W'(wv));
				end
			end
			if ($urandom_range(1) == 1) begin
				case ($urandom_range(4))
					0: hv = 16'd0;
					1: hv = 16'd65535;
					2: hv = 16'd1;
					default: hv = 16'($urandom_range(2, 12));
				endcase
				write_reg(REG_FRAME_HEIGHT, hv);
			end
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if ($urandom_range(2) == 0) begin
					smp = 8'($urandom_range(255));
				end else begin
					smp = last_smp + 8'($urandom_range(8)) - 8'd4;
				end
				last_smp = smp;
				tv = '0;
				send_sample(smp, 1'b0, tv);
			end
		end

		wait_pipeline_empty();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && expected_outputs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/mpc_pkg.sv
sv/mpc_line_buf.sv
sv/mpc_scan_cell.sv
sv/mpc_pred_cell.sv
sv/med_predictive_pixel_codec.sv
sv/mpc_checker.sv
tb/tb_top.sv
